[rtl/core/cbct_pkg.sv]
package cbct_pkg;

  // Decimal coefficients are held as integers scaled by 10^8
  localparam longint DecScale = 64'sd100000000;

  // Select sums, one coefficient per channel (R, G, B)
  localparam longint SelFirst [3] = '{64'sd999000, 64'sd6647390, 64'sd73170000};
  localparam longint SelSecond [3] = '{64'sd15338400, 64'sd31662400, 64'sd5713400};

  // Transform matrices, row-major, three coefficients per output channel
  localparam longint MatFirst [9] = '{
    64'sd42633100, 64'sd87510200, 64'sd8012710,
    64'sd28110000, 64'sd57119500, -64'sd3926270,
    -64'sd1770520, 64'sd2700840, 64'sd100247000
  };

  localparam longint MatSecond [9] = '{
    64'sd75810000, 64'sd145387000, -64'sd148060000,
    64'sd11853200, 64'sd28759500, 64'sd72550100,
    -64'sd746579, 64'sd4487110, 64'sd95430300
  };

  // Number of color channels
  localparam int NumCh = 3;

  // Scaled decimal to signed fixed point with frac fraction bits,
  // rounded to nearest with ties away from zero
  function automatic longint to_fixed(input longint m, input int frac);
    logic   neg;
    longint mag;
    longint num;
    longint q;
    neg = (m < 0);
    mag = neg ? -m : m;
    num = (mag <<< frac) + (DecScale / 2);
    q   = num / DecScale;
    return neg ? -q : q;
  endfunction

endpackage

[rtl/core/cbct_dot3.sv]
// Three-term dot product of signed coefficients and 8-bit unsigned channels.
// Two register stages: products, then their sum.
module cbct_dot3 #(
  parameter int CW = 18,
  parameter int SW = 28
) (
  input  logic                 clk,
  input  logic signed [CW-1:0] coef [cbct_pkg::NumCh],
  input  logic        [7:0]    ch   [cbct_pkg::NumCh],
  output logic signed [SW-1:0] sum
);

  localparam int PW = CW + 9;

  logic signed [PW-1:0] prod [cbct_pkg::NumCh];

  // Product stage, both operands sign-extended to the full product width
  always_ff @(posedge clk) begin
    for (int i = 0; i < cbct_pkg::NumCh; i++) begin
      prod[i] <= PW'(coef[i]) * PW'($signed({1'b0, ch[i]}));
    end
  end

  // Sum stage
  always_ff @(posedge clk) begin
    sum <= SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]);
  end

endmodule

[rtl/core/colorblind_color_transform_unit.sv]
// Colorblind color transform: maps one 8-bit RGB color to its simulated
// dichromat appearance by one of two fixed 3x3 matrices.
//
// Input: drive red_in, green_in, blue_in and raise start. A color transfers
// at every rising edge where start is high and busy is low. busy stays low,
// so a new color may enter on every clock.
//
// Output: done is high for exactly one cycle with red_out, green_out,
// blue_out and matrix_select. Throughput is one color per clock; the
// pipeline has five register stages: select products, select sums, matrix
// products (coefficients chosen by the select compare), matrix sums, and
// round/clamp into the output registers.
//
// The receiver has no way to stall; results are shown once and in order.
// Reset (rst, synchronous) clears the valid bits, dropping colors in flight;
// done stays low until new colors have passed through the pipeline.
module colorblind_color_transform_unit #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  output logic       done,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic       matrix_select
);

  // Coefficients stay below 2.0 in magnitude
  localparam int CW = COEF_FRAC_BITS + 2;
  // Sums of three products with headroom for the rounding offset
  localparam int SW = COEF_FRAC_BITS + 12;
  localparam logic signed [SW-1:0] Half = SW'(1) <<< (COEF_FRAC_BITS - 1);

  logic [5:1] valid;

  logic [7:0] ch_in [cbct_pkg::NumCh];
  logic [7:0] ch1   [cbct_pkg::NumCh];
  logic [7:0] ch2   [cbct_pkg::NumCh];

  logic signed [CW-1:0] k_sel_a [cbct_pkg::NumCh];
  logic signed [CW-1:0] k_sel_b [cbct_pkg::NumCh];
  logic signed [CW-1:0] k_mat [cbct_pkg::NumCh][cbct_pkg::NumCh];

  logic signed [SW-1:0] sum_a;
  logic signed [SW-1:0] sum_b;
  logic signed [SW-1:0] mat_sum [cbct_pkg::NumCh];

  logic       sel;
  logic       sel3;
  logic       sel4;
  logic [7:0] ch_clamped [cbct_pkg::NumCh];
  logic [7:0] out_ch     [cbct_pkg::NumCh];

  assign busy  = 1'b0;
  assign ch_in = '{red_in, green_in, blue_in};

  // Valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[4:1], start & ~busy};
    end
  end

  // Channel delay line, aligned with the select sums
  always_ff @(posedge clk) begin
    ch1 <= ch_in;
    ch2 <= ch1;
  end

  // Select coefficients (folded to constants)
  always_comb begin
    for (int i = 0; i < cbct_pkg::NumCh; i++) begin
      k_sel_a[i] = CW'(cbct_pkg::to_fixed(cbct_pkg::SelFirst[i], COEF_FRAC_BITS));
      k_sel_b[i] = CW'(cbct_pkg::to_fixed(cbct_pkg::SelSecond[i], COEF_FRAC_BITS));
    end
  end

  cbct_dot3 #(.CW(CW), .SW(SW)) u_sel_a (
    .clk  (clk),
    .coef (k_sel_a),
    .ch   (ch_in),
    .sum  (sum_a)
  );

  cbct_dot3 #(.CW(CW), .SW(SW)) u_sel_b (
    .clk  (clk),
    .coef (k_sel_b),
    .ch   (ch_in),
    .sum  (sum_b)
  );

  // Matrix choice: first matrix only when the first sum is strictly below
  assign sel = ~(sum_a < sum_b);

  always_comb begin
    for (int r = 0; r < cbct_pkg::NumCh; r++) begin
      for (int i = 0; i < cbct_pkg::NumCh; i++) begin
        k_mat[r][i] = sel
          ? CW'(cbct_pkg::to_fixed(cbct_pkg::MatSecond[3*r+i], COEF_FRAC_BITS))
          : CW'(cbct_pkg::to_fixed(cbct_pkg::MatFirst[3*r+i], COEF_FRAC_BITS));
      end
    end
  end

  for (genvar r = 0; r < cbct_pkg::NumCh; r++) begin : g_row
    cbct_dot3 #(.CW(CW), .SW(SW)) u_row (
      .clk  (clk),
      .coef (k_mat[r]),
      .ch   (ch2),
      .sum  (mat_sum[r])
    );
  end

  // Select flag follows the matrix products and sums
  always_ff @(posedge clk) begin
    sel3 <= sel;
    sel4 <= sel3;
  end

  // Round half up, then clamp to 0..255
  always_comb begin
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] v;
    for (int r = 0; r < cbct_pkg::NumCh; r++) begin
      t = mat_sum[r] + Half;
      v = t >>> COEF_FRAC_BITS;
      if (t[SW-1]) begin
        ch_clamped[r] = 8'd0;
      end else if (|v[SW-1:8]) begin
        ch_clamped[r] = 8'hFF;
      end else begin
        ch_clamped[r] = v[7:0];
      end
    end
  end

  // Output registers
  always_ff @(posedge clk) begin
    out_ch        <= ch_clamped;
    matrix_select <= sel4;
  end

  assign done      = valid[5];
  assign red_out   = out_ch[0];
  assign green_out = out_ch[1];
  assign blue_out  = out_ch[2];

  // Every accepted color produces a done strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("accepted color did not produce a result after five cycles");

  // No result strobe without an earlier accepted color
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result strobe without a matching accepted color");

  // Reported matrix matches the select compare made for the same color
  a_select_track: assert property (@(posedge clk) disable iff (rst)
    done |-> (matrix_select == $past(!(sum_a < sum_b), 3)))
    else $error("matrix_select out of step with the select compare");

endmodule

[verif/colorblind_color_transform_unit_test.sv]
module colorblind_color_transform_unit_test;

  localparam int     FracBits   = 16;
  localparam longint DecUnit    = 64'sd100000000;
  localparam int     CycleLimit = 200000;
  localparam int     DrainWait  = 10;

  // One transformed color as the block should present it
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       sel;
  } dichromat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [7:0] red_in = 8'd0;
  logic [7:0] green_in = 8'd0;
  logic [7:0] blue_in = 8'd0;
  logic       busy;
  logic       done;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       matrix_select;

  dichromat_t pending_colors [$];
  int         errors = 0;
  int         cycles = 0;

  // Decimal coefficients scaled by 10^8: [0] first set, [1] second set
  longint dec_sel [2][3] = '{
    '{64'sd999000, 64'sd6647390, 64'sd73170000},
    '{64'sd15338400, 64'sd31662400, 64'sd5713400}
  };
  longint dec_mat [2][9] = '{
    '{64'sd42633100, 64'sd87510200, 64'sd8012710,
      64'sd28110000, 64'sd57119500, -64'sd3926270,
      -64'sd1770520, 64'sd2700840, 64'sd100247000},
    '{64'sd75810000, 64'sd145387000, -64'sd148060000,
      64'sd11853200, 64'sd28759500, 64'sd72550100,
      -64'sd746579, 64'sd4487110, 64'sd95430300}
  };

  colorblind_color_transform_unit #(
    .COEF_FRAC_BITS(FracBits)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .red_in(red_in),
    .green_in(green_in),
    .blue_in(blue_in),
    .done(done),
    .red_out(red_out),
    .green_out(green_out),
    .blue_out(blue_out),
    .matrix_select(matrix_select)
  );

  always #4 clk = ~clk;

  // Scaled decimal to fixed point, nearest with ties away from zero
  function automatic longint fixed_coef(longint m);
    longint mag;
    longint q;
    mag = (m < 0) ? -m : m;
    q = (mag * (64'sd1 <<< FracBits) + DecUnit / 2) / DecUnit;
    return (m < 0) ? -q : q;
  endfunction

  // Add half an LSB, floor, clamp to a byte
  function automatic logic [7:0] clamp_channel(longint s);
    longint t;
    t = s + (64'sd1 <<< (FracBits - 1));
    if (t < 0) return 8'd0;
    t = t >>> FracBits;
    return (t > 255) ? 8'd255 : t[7:0];
  endfunction

  function automatic dichromat_t simulate_dichromat(logic [7:0] r, logic [7:0] g,
                                                    logic [7:0] b);
    longint     ch [3];
    longint     sum_a;
    longint     sum_b;
    longint     acc;
    logic [7:0] chan [3];
    int         m;
    dichromat_t res;
    ch[0] = longint'(r);
    ch[1] = longint'(g);
    ch[2] = longint'(b);
    sum_a = 0;
    sum_b = 0;
    for (int j = 0; j < 3; j++) begin
      sum_a += fixed_coef(dec_sel[0][j]) * ch[j];
      sum_b += fixed_coef(dec_sel[1][j]) * ch[j];
    end
    // equal sums fall to the second matrix
    m = (sum_a < sum_b) ? 0 : 1;
    for (int k = 0; k < 3; k++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += fixed_coef(dec_mat[m][3 * k + j]) * ch[j];
      chan[k] = clamp_channel(acc);
    end
    res.red   = chan[0];
    res.green = chan[1];
    res.blue  = chan[2];
    res.sel   = (m == 1);
    return res;
  endfunction

  // One color transfer, after a random idle gap chosen up to max_gap
  task automatic send_color(logic [7:0] r, logic [7:0] g, logic [7:0] b, int max_gap);
    int gap;
    gap = $urandom_range(max_gap, 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    red_in   <= r;
    green_in <= g;
    blue_in  <= b;
    do @(posedge clk); while (busy);
    pending_colors.push_back(simulate_dichromat(r, g, b));
  endtask

  // Hold the input off until every outstanding color is back
  task automatic wait_for_results();
    if (pending_colors.size() != 0) begin
      start <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clk);
    end
  endtask

  // Channel extremes, primaries, clamping and the equal-sum select
  task automatic test_corner_colors();
    send_color(8'd0, 8'd0, 8'd0, 3);       // both sums zero: second matrix
    send_color(8'd255, 8'd255, 8'd255, 3);
    send_color(8'd255, 8'd0, 8'd0, 3);
    send_color(8'd0, 8'd255, 8'd0, 3);
    send_color(8'd0, 8'd0, 8'd255, 3);     // red goes negative, clamps low
    send_color(8'd255, 8'd255, 8'd0, 3);   // red overflows, clamps high
    send_color(8'd0, 8'd255, 8'd255, 3);
    send_color(8'd255, 8'd0, 8'd255, 3);
    send_color(8'd1, 8'd1, 8'd1, 3);
    send_color(8'd1, 8'd0, 8'd0, 3);
    send_color(8'd0, 8'd1, 8'd0, 3);
    send_color(8'd0, 8'd0, 8'd1, 3);
    send_color(8'd128, 8'd128, 8'd128, 3);
    send_color(8'd127, 8'd127, 8'd127, 3);
    send_color(8'h55, 8'hAA, 8'h55, 3);
    send_color(8'hAA, 8'h55, 8'hAA, 3);
    send_color(8'd0, 8'd40, 8'd255, 3);
    send_color(8'd200, 8'd10, 8'd30, 3);
    send_color(8'd30, 8'd60, 8'd20, 3);
    send_color(8'd254, 8'd254, 8'd254, 3);
    wait_for_results();
  endtask

  // Full rate, no idle cycles at all
  task automatic test_back_to_back();
    repeat (60) send_color(8'($urandom), 8'($urandom), 8'($urandom), 0);
  endtask

  // Random colors, some channels pinned to an extreme, with a pause midway
  task automatic test_random_colors();
    logic [7:0] c [3];
    for (int n = 0; n < 1870; n++) begin
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(7, 0))
          0: c[k] = 8'd0;
          1: c[k] = 8'd255;
          default: c[k] = 8'($urandom);
        endcase
      end
      send_color(c[0], c[1], c[2], 3);
      if (n == 900) wait_for_results();
    end
  endtask

  // Compare each result with the oldest outstanding color
  always @(posedge clk) begin : check_results
    dichromat_t want;
    if (!rst && done) begin
      if (pending_colors.size() == 0) begin
        $display("%0t result with nothing outstanding: %0d %0d %0d sel %0d", $time,
                 red_out, green_out, blue_out, matrix_select);
        errors++;
      end else begin
        want = pending_colors.pop_front();
        if (red_out !== want.red) begin
          $display("%0t red_out expected %0d actual %0d", $time, want.red, red_out);
          errors++;
        end
        if (green_out !== want.green) begin
          $display("%0t green_out expected %0d actual %0d", $time, want.green, green_out);
          errors++;
        end
        if (blue_out !== want.blue) begin
          $display("%0t blue_out expected %0d actual %0d", $time, want.blue, blue_out);
          errors++;
        end
        if (matrix_select !== want.sel) begin
          $display("%0t matrix_select expected %0d actual %0d", $time, want.sel,
                   matrix_select);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("[colorblind_color_transform_unit] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_colors();
    test_back_to_back();
    test_random_colors();
    wait_for_results();
    repeat (DrainWait) @(posedge clk);
    if (errors == 0) begin
      $display("[colorblind_color_transform_unit] OK");
    end else begin
      $display("[colorblind_color_transform_unit] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/cbct_pkg.sv
rtl/core/cbct_dot3.sv
rtl/core/colorblind_color_transform_unit.sv
verif/colorblind_color_transform_unit_test.sv
